// File: hw/rtl/mlsc_pkg.sv
// Package: shared constants, types and helpers for the modem LED status classifier.
`default_nettype none
package mlsc_pkg;

    localparam int unsigned POWER_PRESCALE = 10;
    localparam int unsigned POWER_DEBOUNCE = 5;
    localparam int unsigned LINK_DEBOUNCE  = 3;
    localparam int unsigned LENGTH_LIMIT   = 1000;

    localparam int unsigned PRESCALE_W = 4;
    localparam int unsigned PWR_DB_W   = 3;
    localparam int unsigned LINK_DB_W  = 2;
    localparam int unsigned LEN_W      = 10;
    localparam int unsigned CFG_W      = 10;
    localparam int unsigned NUM_CFG    = 8;
    localparam int unsigned CFG_IDX_W  = 3;

    localparam logic [PRESCALE_W-1:0] PRESCALE_LAST = PRESCALE_W'(POWER_PRESCALE - 1);
    localparam logic [PWR_DB_W-1:0]   PWR_DB_MAX    = PWR_DB_W'(POWER_DEBOUNCE);
    localparam logic [LINK_DB_W-1:0]  LINK_DB_MAX   = LINK_DB_W'(LINK_DEBOUNCE);
    localparam logic [LEN_W-1:0]      LEN_MAX       = LEN_W'(LENGTH_LIMIT);

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ON_MIN       = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ON_MAX       = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_UNLINKED_MIN = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_UNLINKED_MAX = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_LINKED_MIN   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_LINKED_MAX   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_GPRS_MIN     = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_GPRS_MAX     = 3'd7;

    localparam logic [CFG_W-1:0] CFG_RESET [NUM_CFG] = '{
        10'd4, 10'd8, 10'd70, 10'd90, 10'd250, 10'd350, 10'd25, 10'd35
    };

    // link status codes
    localparam logic [1:0] LS_UNKNOWN  = 2'd0;
    localparam logic [1:0] LS_UNLINKED = 2'd1;
    localparam logic [1:0] LS_LINKED   = 2'd2;
    localparam logic [1:0] LS_GPRS     = 2'd3;

    // modem status codes
    localparam logic [2:0] MS_POWER_OFF    = 3'd0;
    localparam logic [2:0] MS_UNCLASSIFIED = 3'd4;

    typedef struct packed {
        logic [CFG_W-1:0] on_min;
        logic [CFG_W-1:0] on_max;
        logic [CFG_W-1:0] unlinked_min;
        logic [CFG_W-1:0] unlinked_max;
        logic [CFG_W-1:0] linked_min;
        logic [CFG_W-1:0] linked_max;
        logic [CFG_W-1:0] gprs_min;
        logic [CFG_W-1:0] gprs_max;
    } link_win_t;

    function automatic logic in_window(
        input logic [LEN_W-1:0] v,
        input logic [CFG_W-1:0] lo,
        input logic [CFG_W-1:0] hi
    );
        return (v > lo) && (v < hi);
    endfunction

endpackage
`default_nettype wire

// File: hw/rtl/modem_led_status_classifier.sv
// Top level: input register, power and link units, config registers, result register.
// A request passes from the input register through the power and link units to the result register.
// Throughput: one request per cycle; the input and result registers stall together.
// Each request updates the power and link state in one pass of short logic.
// Reset clears the control and classifier state: power off, link unknown, windows at their default values.
// No clearing pass is needed after reset.
`default_nettype none
module modem_led_status_classifier (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              in_valid,
    output logic                                   in_ready,
    input  wire logic                              power_led_lit,
    input  wire logic                              link_led_lit,
    output logic                                   out_valid,
    input  wire logic                              out_ready,
    output logic [2:0]                             modem_status,
    output logic [1:0]                             link_status,
    output logic                                   power_on,
    input  wire logic                              cfg_wr_en,
    input  wire logic [mlsc_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [mlsc_pkg::CFG_W-1:0]        cfg_wdata
);

    logic [mlsc_pkg::CFG_W-1:0] cfg_reg [mlsc_pkg::NUM_CFG];
    mlsc_pkg::link_win_t        win;

    logic       in_vld_reg;
    logic       pwr_lit_reg;
    logic       lnk_lit_reg;
    logic       out_vld_reg;
    logic [2:0] modem_status_reg, modem_status_next;
    logic [1:0] link_status_reg;
    logic       power_on_reg;
    logic       advance;
    logic       step;
    logic       power_next;
    logic [1:0] link_next;

    assign advance  = !out_vld_reg || out_ready;
    assign in_ready = !in_vld_reg || advance;
    assign step     = in_vld_reg && advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < mlsc_pkg::NUM_CFG; i++)
                cfg_reg[i] <= mlsc_pkg::CFG_RESET[i];
        end
        else if (cfg_wr_en)
        begin
            cfg_reg[cfg_index] <= cfg_wdata;
        end
    end

    always_comb
    begin
        win.on_min       = cfg_reg[mlsc_pkg::CFG_ON_MIN];
        win.on_max       = cfg_reg[mlsc_pkg::CFG_ON_MAX];
        win.unlinked_min = cfg_reg[mlsc_pkg::CFG_UNLINKED_MIN];
        win.unlinked_max = cfg_reg[mlsc_pkg::CFG_UNLINKED_MAX];
        win.linked_min   = cfg_reg[mlsc_pkg::CFG_LINKED_MIN];
        win.linked_max   = cfg_reg[mlsc_pkg::CFG_LINKED_MAX];
        win.gprs_min     = cfg_reg[mlsc_pkg::CFG_GPRS_MIN];
        win.gprs_max     = cfg_reg[mlsc_pkg::CFG_GPRS_MAX];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_vld_reg <= 1'b0;
        else if (in_ready)
            in_vld_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            pwr_lit_reg <= power_led_lit;
            lnk_lit_reg <= link_led_lit;
        end
    end

    mlsc_power u_power (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (step),
        .lit        (pwr_lit_reg),
        .power_next (power_next)
    );

    mlsc_link u_link (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (step),
        .lit       (lnk_lit_reg),
        .win       (win),
        .link_next (link_next)
    );

    always_comb
    begin
        if (!power_next)
            modem_status_next = mlsc_pkg::MS_POWER_OFF;
        else if (link_next == mlsc_pkg::LS_UNKNOWN)
            modem_status_next = mlsc_pkg::MS_UNCLASSIFIED;
        else
            modem_status_next = {1'b0, link_next};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_vld_reg <= 1'b0;
        else if (advance)
            out_vld_reg <= in_vld_reg;
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            modem_status_reg <= modem_status_next;
            link_status_reg  <= link_next;
            power_on_reg     <= power_next;
        end
    end

    assign out_valid    = out_vld_reg;
    assign modem_status = modem_status_reg;
    assign link_status  = link_status_reg;
    assign power_on     = power_on_reg;

`ifndef NO_ASSERTIONS
    a_off_status: assert property (@(posedge clk) disable iff (!rst_n)
        (out_vld_reg && !power_on_reg) |-> (modem_status_reg == mlsc_pkg::MS_POWER_OFF))
        else $error("power off but modem status not off");
    a_unknown_status: assert property (@(posedge clk) disable iff (!rst_n)
        (out_vld_reg && power_on_reg && (link_status_reg == mlsc_pkg::LS_UNKNOWN))
            |-> (modem_status_reg == mlsc_pkg::MS_UNCLASSIFIED))
        else $error("unknown link not reported as unknown");
    a_input_held: assert property (@(posedge clk) disable iff (!rst_n)
        (in_vld_reg && !advance) |=> (in_vld_reg && $stable(pwr_lit_reg)
            && $stable(lnk_lit_reg)))
        else $error("input register lost a stalled request");
`endif

endmodule
`default_nettype wire

// File: hw/rtl/mlsc_power.sv
// Power LED prescaler and up/down debounce giving the power state.
`default_nettype none
module mlsc_power (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic en,
    input  wire logic lit,
    output logic      power_next
);

    logic [mlsc_pkg::PRESCALE_W-1:0] prescale_reg, prescale_next;
    logic [mlsc_pkg::PWR_DB_W-1:0]   debounce_reg, debounce_next;
    logic                            power_reg;

    always_comb
    begin
        prescale_next = prescale_reg + 1'b1;
        debounce_next = debounce_reg;
        power_next    = power_reg;
        if (prescale_reg >= mlsc_pkg::PRESCALE_LAST)
        begin
            prescale_next = '0;
            if (lit)
            begin
                if (debounce_reg < mlsc_pkg::PWR_DB_MAX)
                    debounce_next = debounce_reg + 1'b1;
                else
                    power_next = 1'b1;
            end
            else
            begin
                if (debounce_reg != '0)
                    debounce_next = debounce_reg - 1'b1;
                else
                    power_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prescale_reg <= '0;
            debounce_reg <= '0;
            power_reg    <= 1'b0;
        end
        else if (en)
        begin
            prescale_reg <= prescale_next;
            debounce_reg <= debounce_next;
            power_reg    <= power_next;
        end
    end

endmodule
`default_nettype wire

// File: hw/rtl/mlsc_link.sv
// Link LED edge debounce, lit/dark length counters and blink classification.
`default_nettype none
module mlsc_link (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                en,
    input  wire logic                lit,
    input  wire mlsc_pkg::link_win_t win,
    output logic [1:0]               link_next
);

    logic [mlsc_pkg::LINK_DB_W-1:0] rise_reg, rise_next;
    logic [mlsc_pkg::LINK_DB_W-1:0] fall_reg, fall_next;
    logic [mlsc_pkg::LEN_W-1:0]     lit_len_reg, lit_len_next;
    logic [mlsc_pkg::LEN_W-1:0]     dark_len_reg, dark_len_next;
    logic [mlsc_pkg::LEN_W-1:0]     last_lit_reg, last_lit_next;
    logic [1:0]                     link_reg;
    logic [1:0]                     class_code;

    always_comb
    begin
        if (mlsc_pkg::in_window(dark_len_reg, win.unlinked_min, win.unlinked_max))
            class_code = mlsc_pkg::LS_UNLINKED;
        else if (mlsc_pkg::in_window(dark_len_reg, win.linked_min, win.linked_max))
            class_code = mlsc_pkg::LS_LINKED;
        else if (mlsc_pkg::in_window(dark_len_reg, win.gprs_min, win.gprs_max))
            class_code = mlsc_pkg::LS_GPRS;
        else
            class_code = mlsc_pkg::LS_UNKNOWN;
    end

    always_comb
    begin
        rise_next     = rise_reg;
        fall_next     = fall_reg;
        lit_len_next  = lit_len_reg;
        dark_len_next = dark_len_reg;
        last_lit_next = last_lit_reg;
        link_next     = link_reg;
        if (lit)
        begin
            fall_next = '0;
            if (rise_reg < mlsc_pkg::LINK_DB_MAX)
            begin
                rise_next = rise_reg + 1'b1;
                if (rise_next == mlsc_pkg::LINK_DB_MAX)
                begin
                    // qualified rising edge
                    if (mlsc_pkg::in_window(last_lit_reg, win.on_min, win.on_max))
                        link_next = class_code;
                    dark_len_next = '0;
                end
            end
            if (lit_len_reg < mlsc_pkg::LEN_MAX)
                lit_len_next = lit_len_reg + 1'b1;
        end
        else
        begin
            rise_next = '0;
            if (fall_reg < mlsc_pkg::LINK_DB_MAX)
            begin
                fall_next = fall_reg + 1'b1;
                if (fall_next == mlsc_pkg::LINK_DB_MAX)
                begin
                    last_lit_next = lit_len_reg;
                    lit_len_next  = '0;
                end
            end
            if (dark_len_reg < mlsc_pkg::LEN_MAX)
                dark_len_next = dark_len_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rise_reg     <= '0;
            fall_reg     <= '0;
            lit_len_reg  <= '0;
            dark_len_reg <= '0;
            last_lit_reg <= '0;
            link_reg     <= mlsc_pkg::LS_UNKNOWN;
        end
        else if (en)
        begin
            rise_reg     <= rise_next;
            fall_reg     <= fall_next;
            lit_len_reg  <= lit_len_next;
            dark_len_reg <= dark_len_next;
            last_lit_reg <= last_lit_next;
            link_reg     <= link_next;
        end
    end

`ifndef NO_ASSERTIONS
    a_one_debounce_active: assert property (@(posedge clk) disable iff (!rst_n)
        (rise_reg == '0) || (fall_reg == '0))
        else $error("rise and fall debounce both active");
    a_lengths_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        (lit_len_reg <= mlsc_pkg::LEN_MAX) && (dark_len_reg <= mlsc_pkg::LEN_MAX))
        else $error("length counter beyond limit");
    a_link_only_on_rise: assert property (@(posedge clk) disable iff (!rst_n)
        (en && (link_next != link_reg)) |=>
            (rise_reg == mlsc_pkg::LINK_DB_MAX) && (dark_len_reg == '0))
        else $error("link state changed outside a qualified rising edge");
`endif

endmodule
`default_nettype wire
